FILE: hw/rtl/hashed_timer_wheel_macros.svh
// assertion macros used by the timer wheel checker
`ifndef HASHED_TIMER_WHEEL_MACROS_SVH
`define HASHED_TIMER_WHEEL_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define HTW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer wheel check failed");

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define HTW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer wheel check failed");

`endif

FILE: hw/rtl/htw_pkg.sv
// shared constants and command codes for the hashed timer wheel
package htw_pkg;

	localparam int CMD_W          = 2;
	localparam int CLIENT_W       = 6;
	localparam int TIMEOUT_W      = 32;
	localparam int MS_PER_SECOND  = 1000;
	localparam int MIN_TIMEOUT_MS = 1;

	localparam int WHEEL_SLOTS_DEF  = 64;
	localparam int TICK_SECONDS_DEF = 1;
	localparam int MAX_CLIENTS_DEF  = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_TICK   = 2'd2
	} cmd_t;

endpackage

FILE: hw/rtl/htw_ram.sv
// generic single-write, single-read ram with registered read data
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/hashed_timer_wheel.sv
// hashed timer wheel: add, remove and tick commands with per-client expiry reports
//
//  channel  beat fields                        handshake
//  -------  ---------------------------------  -------------------------
//  in       cmd, client_id, timeout            in_valid / in_stall
//  out      expired_client, last_expired       out_valid / out_stall
//
// remove and unused codes are done in the idle state; add runs three passes through one
// shared 32x32 multiplier (reciprocal divide by the tick length, reciprocal divide by
// the wheel size, multiply back for the remainder); ST_FIN then writes the slot ram
// tick reads one client per cycle, except while the output holds the scan
// reset clears the armed bits and the current slot at once; no clearing pass
// out_stall holds the scan when a second hit or the final flush needs the register
module hashed_timer_wheel
	import htw_pkg::*;
#(
	parameter int WHEEL_SLOTS  = WHEEL_SLOTS_DEF,
	parameter int TICK_SECONDS = TICK_SECONDS_DEF,
	parameter int MAX_CLIENTS  = MAX_CLIENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [CMD_W-1:0]            cmd,
	input  logic [CLIENT_W-1:0]         client_id,
	input  logic signed [TIMEOUT_W-1:0] timeout,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [CLIENT_W-1:0]         expired_client,
	output logic                        last_expired
);

	localparam int SLOT_W  = $clog2(WHEEL_SLOTS);
	localparam int IDX_W   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CNT_W   = $clog2(MAX_CLIENTS + 1);
	localparam int DIVISOR = MS_PER_SECOND * TICK_SECONDS;
	localparam int PROD_W  = 2 * TIMEOUT_W;

	// floor(n / d) == (n * ceil(2^s / d)) >> s for n below 2^31 with s = 31 + clog2(d)
	localparam int     DIV_SHIFT = TIMEOUT_W - 1 + $clog2(DIVISOR);
	localparam int     WHL_SHIFT = TIMEOUT_W - 1 + $clog2(WHEEL_SLOTS);
	localparam longint RECIP_DIV = ((longint'(1) << DIV_SHIFT) + longint'(DIVISOR - 1)) /
		longint'(DIVISOR);
	localparam longint RECIP_WHL = ((longint'(1) << WHL_SHIFT) + longint'(WHEEL_SLOTS - 1)) /
		longint'(WHEEL_SLOTS);

	// multiplier passes of one add
	localparam logic [1:0] P_TICKS = 2'd0;
	localparam logic [1:0] P_TURNS = 2'd1;
	localparam logic [1:0] P_BACK  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN,
		ST_SCAN
	} state_t;

	state_t                 state_q;
	logic [SLOT_W-1:0]      cur_q;
	logic [MAX_CLIENTS-1:0] armed_q;
	logic [IDX_W-1:0]       id_q;
	logic [TIMEOUT_W-1:0]   opa_q;
	logic [SLOT_W-1:0]      qlo_q;
	logic [SLOT_W-1:0]      qmod_q;
	logic [1:0]             step_q;
	logic [CNT_W-1:0]       scan_q;
	logic                   cmp_vld_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;
	logic                   pend_vld_q;
	logic [IDX_W-1:0]       pend_id_q;
	logic                   out_vld_q;
	logic [CLIENT_W-1:0]    out_id_q;
	logic                   out_last_q;

	logic                   id_ok;
	logic [TIMEOUT_W-1:0]   ms_in;
	logic [TIMEOUT_W-1:0]   mul_b;
	logic [PROD_W-1:0]      prod;
	logic [TIMEOUT_W-1:0]   tick_quo;
	logic [TIMEOUT_W-1:0]   turn_quo;
	logic [SLOT_W:0]        fin_sum;
	logic [SLOT_W-1:0]      slot_fin;
	logic [SLOT_W:0]        cur_inc;
	logic [SLOT_W-1:0]      cur_nx;
	logic [SLOT_W-1:0]      rd_slot;
	logic                   out_free;
	logic                   rd_hit;
	logic                   hold;
	logic                   rd_more;
	logic                   rd_go;
	logic                   ram_we;
	logic                   out_load;

	assign id_ok = {1'b0, client_id} < (CLIENT_W + 1)'(MAX_CLIENTS);
	assign ms_in = (timeout <= 32'sd0) ? TIMEOUT_W'(MIN_TIMEOUT_MS) : timeout;

	// shared multiplier, constant operand picked by the pass
	always_comb begin
		case (step_q)
			P_TICKS: mul_b = TIMEOUT_W'(RECIP_DIV);
			P_TURNS: mul_b = TIMEOUT_W'(RECIP_WHL);
			default: mul_b = TIMEOUT_W'(WHEEL_SLOTS);
		endcase
	end

	assign prod     = PROD_W'(opa_q) * PROD_W'(mul_b);
	assign tick_quo = TIMEOUT_W'(prod >> DIV_SHIFT);
	assign turn_quo = TIMEOUT_W'(prod >> WHL_SHIFT);

	assign fin_sum  = {1'b0, cur_q} + {1'b0, qmod_q};
	assign slot_fin = (fin_sum >= (SLOT_W + 1)'(WHEEL_SLOTS)) ?
		SLOT_W'(fin_sum - (SLOT_W + 1)'(WHEEL_SLOTS)) : fin_sum[SLOT_W-1:0];

	assign cur_inc = {1'b0, cur_q} + (SLOT_W + 1)'(1);
	assign cur_nx  = (cur_inc == (SLOT_W + 1)'(WHEEL_SLOTS)) ? '0 : cur_inc[SLOT_W-1:0];

	// scan control: a hit needs the output only when an earlier hit is pending
	assign out_free = !out_vld_q || !out_stall;
	assign rd_hit   = cmp_vld_s1 && armed_q[cmp_idx_s1] && (rd_slot == cur_q);
	assign hold     = rd_hit && pend_vld_q && !out_free;
	assign rd_more  = scan_q < CNT_W'(MAX_CLIENTS);
	assign rd_go    = (state_q == ST_SCAN) && rd_more && !hold;
	assign ram_we   = state_q == ST_FIN;
	assign out_load = (state_q == ST_SCAN) && !hold && pend_vld_q &&
		(rd_hit || (!rd_more && !cmp_vld_s1 && out_free));

	htw_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(MAX_CLIENTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(id_q),
		.wdata(slot_fin),
		.re   (rd_go),
		.raddr(scan_q[IDX_W-1:0]),
		.rdata(rd_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			armed_q    <= '0;
			step_q     <= '0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (cmd)
							CMD_ADD: begin
								if (id_ok) begin
									id_q    <= client_id[IDX_W-1:0];
									opa_q   <= ms_in;
									step_q  <= P_TICKS;
									state_q <= ST_MUL;
								end
							end
							CMD_REMOVE: begin
								if (id_ok) begin
									armed_q[client_id[IDX_W-1:0]] <= 1'b0;
								end
							end
							CMD_TICK: begin
								cur_q      <= cur_nx;
								scan_q     <= '0;
								cmp_vld_s1 <= 1'b0;
								pend_vld_q <= 1'b0;
								state_q    <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					case (step_q)
						P_TICKS: begin
							opa_q  <= tick_quo;
							qlo_q  <= tick_quo[SLOT_W-1:0];
							step_q <= P_TURNS;
						end
						P_TURNS: begin
							opa_q  <= turn_quo;
							step_q <= P_BACK;
						end
						default: begin
							// ticks minus whole turns, fits in the slot width
							qmod_q  <= qlo_q - prod[SLOT_W-1:0];
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_FIN: begin
					armed_q[id_q] <= 1'b1;
					state_q       <= ST_IDLE;
				end
				ST_SCAN: begin
					if (!hold) begin
						if (rd_hit) begin
							armed_q[cmp_idx_s1] <= 1'b0;
							pend_id_q           <= cmp_idx_s1;
							pend_vld_q          <= 1'b1;
							if (pend_vld_q) begin
								out_id_q   <= CLIENT_W'(pend_id_q);
								out_last_q <= 1'b0;
							end
						end
						cmp_vld_s1 <= rd_more;
						cmp_idx_s1 <= scan_q[IDX_W-1:0];
						if (rd_more) begin
							scan_q <= scan_q + CNT_W'(1);
						end
						// scan finished: flush the held hit as the last beat
						if (!rd_more && !cmp_vld_s1) begin
							if (pend_vld_q) begin
								if (out_free) begin
									out_id_q   <= CLIENT_W'(pend_id_q);
									out_last_q <= 1'b1;
									pend_vld_q <= 1'b0;
									state_q    <= ST_IDLE;
								end
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = state_q != ST_IDLE;
	assign out_valid      = out_vld_q;
	assign expired_client = out_id_q;
	assign last_expired   = out_last_q;

endmodule

FILE: hw/rtl/htw_checker.sv
// port-level checker for the hashed timer wheel, bound to the top level
`include "hashed_timer_wheel_macros.svh"

module htw_checker
	import htw_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [CMD_W-1:0]            cmd,
	input logic [CLIENT_W-1:0]         client_id,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [CLIENT_W-1:0]         expired_client,
	input logic                        last_expired
);

	logic              in_beat;
	logic              id_in_range;
	logic [CLIENT_W:0] out_beat;

	assign in_beat     = in_valid && !in_stall;
	assign id_in_range = {1'b0, client_id} < (CLIENT_W + 1)'(MAX_CLIENTS_DEF);
	assign out_beat    = {expired_client, last_expired};

	// a stalled result beat holds
	`HTW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))

	// a tick always starts a scan that blocks the input
	`HTW_ASSERT_NEXT(a_tick_busy, in_beat && cmd == CMD_TICK, in_stall)

	// an add for a client in range runs the multiplier passes
	`HTW_ASSERT_NEXT(a_add_busy, in_beat && cmd == CMD_ADD && id_in_range, in_stall)

	// once the block is free again only the closing beat of a tick may wait
	`HTW_ASSERT_NOW(a_idle_last, out_valid && !in_stall, last_expired)

endmodule

bind hashed_timer_wheel htw_checker u_htw_checker (.*);

FILE: sim/hashed_timer_wheel_tb.sv
// self-checking testbench for the hashed timer wheel: directed table, then random traffic
module hashed_timer_wheel_tb;
	import htw_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS    = 50;
	localparam int IDLE_LIMIT      = 3000;
	localparam int TAIL_CYCLES     = 80;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int REPORT_MAX      = 10;
	localparam int STIM_ROWS       = 21;

	typedef struct packed {
		logic [CLIENT_W-1:0] client;
		logic                last;
	} expiry_t;

	typedef struct {
		logic [CMD_W-1:0]            op;
		logic [CLIENT_W-1:0]         client;
		logic signed [TIMEOUT_W-1:0] tmo;
		int                          reps;
		bit                          typed;
		bit                          has_beat;
		logic [CLIENT_W-1:0]         want_client;
		logic                        want_last;
	} stim_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [CMD_W-1:0]            cmd = CMD_ADD;
	logic [CLIENT_W-1:0]         client_id = '0;
	logic signed [TIMEOUT_W-1:0] timeout = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [CLIENT_W-1:0]         expired_client;
	logic                        last_expired;

	hashed_timer_wheel uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.client_id      (client_id),
		.timeout        (timeout),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.expired_client (expired_client),
		.last_expired   (last_expired)
	);

	// directed rows; reps > 1 repeats the row with client_id stepping up by one
	stim_row_t stim_tab [STIM_ROWS] = '{
		'{CMD_TICK,   6'd0,  32'sd0,          1,  1'b1, 1'b0, 6'd0,  1'b0},
		'{CMD_ADD,    6'd0,  32'sd0,          1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_ADD,    6'd63, 32'sh8000_0000,  1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_ADD,    6'd5,  32'sd1000,       1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_TICK,   6'd0,  32'sd0,          1,  1'b1, 1'b1, 6'd5,  1'b1},
		'{CMD_ADD,    6'd10, 32'sh7FFF_FFFF,  1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_ADD,    6'd10, 32'sd1999,       1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_REMOVE, 6'd20, 32'sd0,          1,  1'b1, 1'b0, 6'd0,  1'b0},
		'{CMD_UNUSED, 6'd63, 32'shFFFF_FFFF,  1,  1'b1, 1'b0, 6'd0,  1'b0},
		'{CMD_TICK,   6'd0,  32'sd0,          1,  1'b1, 1'b1, 6'd10, 1'b1},
		'{CMD_ADD,    6'd7,  32'sd64000,      1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_REMOVE, 6'd63, 32'sd0,          1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_ADD,    6'd1,  32'shFFFF_FFFF,  1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_TICK,   6'd0,  32'sd0,          63, 1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_TICK,   6'd0,  32'sd0,          1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_ADD,    6'd0,  32'sd5000,       64, 1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_TICK,   6'd0,  32'sd0,          5,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_ADD,    6'd2,  32'sd999,        1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_ADD,    6'd3,  32'sd63999,      1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_REMOVE, 6'd2,  32'sd0,          1,  1'b0, 1'b0, 6'd0,  1'b0},
		'{CMD_TICK,   6'd0,  32'sd0,          3,  1'b0, 1'b0, 6'd0,  1'b0}
	};

	// predicted wheel state
	bit          wheel_armed [MAX_CLIENTS_DEF];
	int unsigned wheel_slot [MAX_CLIENTS_DEF];
	int unsigned wheel_now = 0;

	expiry_t expiry_q [$];
	expiry_t want_beat;

	int  n_mismatch = 0;
	int  n_add = 0, n_remove = 0, n_tick = 0, n_other = 0;
	int  n_pred_beats = 0, n_beats = 0, max_burst = 0;
	int  tx_items = 0, rx_items = 0;
	bit  tx_calm = 1'b0, rx_calm = 1'b0;
	bit  hold_off_done = 1'b0;
	int  stall_left = 0;
	int  idle_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
		n_mismatch++;
		if (n_mismatch <= REPORT_MAX)
			$display("mismatch: %s expected %0h got %0h", what, want, got);
	endtask

	task automatic wheel_predict(input logic [CMD_W-1:0] op, input logic [CLIENT_W-1:0] cid,
			input logic [TIMEOUT_W-1:0] tmo, input bit keep);
		logic [TIMEOUT_W-1:0] ms;
		int unsigned          nticks;
		expiry_t              hits [$];
		hits = {};
		case (op)
			CMD_ADD: begin
				n_add++;
				if (cid < MAX_CLIENTS_DEF) begin
					// zero and negative timeouts count as the minimum
					ms = (tmo == 0 || tmo[TIMEOUT_W-1]) ? MIN_TIMEOUT_MS : tmo;
					nticks = (ms / MS_PER_SECOND) / TICK_SECONDS_DEF;
					wheel_slot[cid] = (wheel_now + nticks % WHEEL_SLOTS_DEF) % WHEEL_SLOTS_DEF;
					wheel_armed[cid] = 1'b1;
				end
			end
			CMD_REMOVE: begin
				n_remove++;
				if (cid < MAX_CLIENTS_DEF)
					wheel_armed[cid] = 1'b0;
			end
			CMD_TICK: begin
				n_tick++;
				wheel_now = (wheel_now + 1) % WHEEL_SLOTS_DEF;
				for (int c = 0; c < MAX_CLIENTS_DEF; c++) begin
					if (wheel_armed[c] && wheel_slot[c] == wheel_now) begin
						wheel_armed[c] = 1'b0;
						hits.push_back('{client: c[CLIENT_W-1:0], last: 1'b0});
					end
				end
				if (hits.size() > 0)
					hits[hits.size()-1].last = 1'b1;
			end
			default: n_other++;
		endcase
		if (hits.size() > max_burst)
			max_burst = hits.size();
		if (keep) begin
			n_pred_beats += hits.size();
			foreach (hits[i])
				expiry_q.push_back(hits[i]);
		end
	endtask

	task automatic send_beat(input logic [CMD_W-1:0] op, input logic [CLIENT_W-1:0] cid,
			input logic signed [TIMEOUT_W-1:0] tmo, input bit keep);
		in_valid <= 1'b1;
		cmd <= op;
		client_id <= cid;
		timeout <= tmo;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		wheel_predict(op, cid, tmo, keep);
	endtask

	task automatic sender_gap();
		int gap;
		tx_items++;
		if (tx_items % 24 == 0)
			tx_calm = ($urandom_range(0, 3) == 0);
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: check each beat against the oldest expectation, then stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			n_beats++;
			if (expiry_q.size() == 0) begin
				flag_mismatch("beat with nothing pending, client", '1, 32'(expired_client));
			end else begin
				want_beat = expiry_q.pop_front();
				if (expired_client !== want_beat.client)
					flag_mismatch("expired_client", 32'(want_beat.client),
						32'(expired_client));
				if (last_expired !== want_beat.last)
					flag_mismatch("last_expired", 32'(want_beat.last), 32'(last_expired));
			end
			rx_items++;
			if (rx_items % 24 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			// one long hold-off inside a burst so the scan backs up into the command side
			if (!hold_off_done && last_expired === 1'b0) begin
				stall_left = HOLD_OFF_CYCLES;
				hold_off_done = 1'b1;
			end else begin
				stall_left = rx_calm ? 0 : $urandom_range(0, 15);
			end
			out_stall <= (stall_left != 0);
		end else if (stall_left != 0) begin
			stall_left--;
			if (stall_left == 0)
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [CLIENT_W-1:0]         cid;
		logic [CMD_W-1:0]            op;
		logic signed [TIMEOUT_W-1:0] tmo;
		int                          pick;

		foreach (wheel_armed[c]) begin
			wheel_armed[c] = 1'b0;
			wheel_slot[c] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_tab[r]) begin
			for (int k = 0; k < stim_tab[r].reps; k++) begin
				cid = CLIENT_W'(stim_tab[r].client + k);
				send_beat(stim_tab[r].op, cid, stim_tab[r].tmo, !stim_tab[r].typed);
				if (stim_tab[r].typed && stim_tab[r].has_beat)
					expiry_q.push_back('{client: stim_tab[r].want_client,
						last: stim_tab[r].want_last});
				sender_gap();
			end
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			cid = CLIENT_W'($urandom_range(0, 63));
			tmo = $urandom;
			if (pick < 40) begin
				op = CMD_ADD;
				// mostly timeouts that land inside one turn of the wheel
				case ($urandom_range(0, 9))
					0: tmo = $urandom | 32'h8000_0000;
					1: tmo = $urandom;
					2: tmo = '0;
					default: tmo = $urandom_range(0, 70000);
				endcase
			end else if (pick < 55) begin
				op = CMD_REMOVE;
			end else if (pick < 95) begin
				op = CMD_TICK;
			end else begin
				op = CMD_UNUSED;
			end
			send_beat(op, cid, tmo, 1'b1);
			sender_gap();
		end
		in_valid <= 1'b0;

		while (expiry_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d adds, %0d removes, %0d ticks and %0d unused codes",
			n_add, n_remove, n_tick, n_other);
		$display("checked %0d expiry beats (%0d from the model), up to %0d on a single tick",
			n_beats, n_pred_beats, max_burst);
		if (n_mismatch == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/htw_pkg.sv
hw/rtl/htw_ram.sv
hw/rtl/hashed_timer_wheel.sv
hw/rtl/htw_checker.sv
sim/hashed_timer_wheel_tb.sv
